@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// Clocked assertions with and without a synchronous reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/gws_pkg.sv @@
// Types and constants of the grid word search block.
// Used by the stream interfaces, all RTL modules and the checker.
`timescale 1ns / 1ps

package gws_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GSZ_W      = 6;
  localparam logic [GSZ_W-1:0] GRID_SIZE_RST = 6'd32;

  // Input function codes
  localparam logic FUNC_CELL = 1'b0;
  localparam logic FUNC_WORD = 1'b1;

  // Reported direction codes
  localparam logic [1:0] DIR_HORZ = 2'd0;
  localparam logic [1:0] DIR_VERT = 2'd1;
  localparam logic [1:0] DIR_DIAG = 2'd2;

  // Operations queued from the front end to the search engine
  localparam logic [1:0] OP_GRID   = 2'd0;  // write one grid cell
  localparam logic [1:0] OP_WORD   = 2'd1;  // store one word character
  localparam logic [1:0] OP_SEARCH = 2'd2;  // store last character, then search
  localparam logic [1:0] OP_MISS   = 2'd3;  // last character out of range: not found

  typedef struct packed {
    logic       func;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic [7:0] symbol;
    logic [4:0] word_pos;
    logic       word_end;
  } gws_req_t;

  typedef struct packed {
    logic       found;
    logic [4:0] hit_row;
    logic [4:0] hit_col;
    logic [1:0] direction;
  } gws_rsp_t;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] symbol;
    logic [4:0] pos;
  } gws_q_t;

endpackage

@@ rtl/core/gws_if.sv @@
// Valid/ready stream interfaces for requests and results.
// Depends on gws_pkg for the payload types.
`timescale 1ns / 1ps

interface gws_req_if;
  logic              valid;
  logic              ready;
  gws_pkg::gws_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gws_rsp_if;
  logic              valid;
  logic              ready;
  gws_pkg::gws_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/gws_front.sv @@
// Front end: accepts requests, sorts them into engine operations and
// queues them in a two-entry FIFO. Depends on gws_pkg and gws_if.
`timescale 1ns / 1ps

module gws_front #(
  parameter int GRID_MAX = 32,
  parameter int WORD_MAX = 32
) (
  input  logic            clk,
  input  logic            rst,
  gws_req_if.sink         req,
  output logic            q_valid,
  output gws_pkg::gws_q_t q_entry,
  input  logic            q_ready
);
  import gws_pkg::*;

  localparam int unsigned GRID_LIM = GRID_MAX;
  localparam int unsigned WORD_LIM = WORD_MAX;

  gws_q_t     slot [2];
  gws_q_t     entry;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;
  logic       cell_ok;
  logic       pos_ok;

  assign cell_ok = (32'(req.data.cell_row) < GRID_LIM) && (32'(req.data.cell_col) < GRID_LIM);
  assign pos_ok  = 32'(req.data.word_pos) < WORD_LIM;

  always_comb begin
    entry.row    = req.data.cell_row;
    entry.col    = req.data.cell_col;
    entry.symbol = req.data.symbol;
    entry.pos    = req.data.word_pos;
    if (req.data.func == FUNC_CELL) begin
      entry.op = OP_GRID;
      keep     = cell_ok;
    end else if (!req.data.word_end) begin
      entry.op = OP_WORD;
      keep     = pos_ok;
    end else begin
      entry.op = pos_ok ? OP_SEARCH : OP_MISS;
      keep     = 1'b1;
    end
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready && keep;
  assign q_valid   = (count != 2'd0);
  assign q_entry   = slot[rd_ptr];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

endmodule

@@ rtl/core/gws_back.sv @@
// Search engine: grid and word memories, scan sequencer and result register.
// Depends on gws_pkg and gws_if.
`timescale 1ns / 1ps

module gws_back #(
  parameter int GRID_MAX = 32,
  parameter int WORD_MAX = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gws_pkg::GSZ_W-1:0] grid_size,
  input  logic                      q_valid,
  input  gws_pkg::gws_q_t           q_entry,
  output logic                      q_ready,
  gws_rsp_if.source                 rsp
);
  import gws_pkg::*;

  localparam int GW     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW     = $clog2(GRID_MAX + 1);
  localparam int PW     = NW + 1;
  localparam int WA     = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int GDEPTH = GRID_MAX * GRID_MAX;
  localparam int GA     = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // scan passes, in search order
  localparam logic [1:0] SCAN_H  = 2'd0;
  localparam logic [1:0] SCAN_V  = 2'd1;
  localparam logic [1:0] SCAN_DR = 2'd2;
  localparam logic [1:0] SCAN_UR = 2'd3;

  logic [7:0] grid_mem [GDEPTH];
  logic [7:0] word_mem [WORD_MAX];
  logic [7:0] grid_rd;
  logic [7:0] word_rd;

  logic [1:0]           state, state_next;
  logic [1:0]           dir, dir_next;
  logic [GW-1:0]        r, r_next;
  logic [GW-1:0]        c, c_next;
  logic [WA-1:0]        k, k_next;
  logic [WA-1:0]        len_m1, len_m1_next;
  logic [NW-1:0]        n, n_next;
  logic signed [PW-1:0] cur_r, cur_r_next;
  logic signed [PW-1:0] cur_c, cur_c_next;
  logic                 hit, hit_next;
  logic [GW-1:0]        hit_r, hit_r_next;
  logic [GW-1:0]        hit_c, hit_c_next;
  logic [1:0]           hit_dir, hit_dir_next;

  logic [NW:0]   n_calc;
  logic          adv;
  logic          outside;
  logic          c_last;
  logic          r_last;
  logic          pop;
  logic          load;
  logic          rsp_valid;
  logic [GA-1:0] grid_waddr;
  logic [GA-1:0] grid_raddr;
  logic          grid_we;
  logic          word_we;

  assign n_calc = ({1'b0, grid_size} > 7'(GRID_MAX)) ? (NW+1)'(GRID_MAX) : (NW+1)'(grid_size);

  assign q_ready = (state == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign grid_we = pop && (q_entry.op == OP_GRID);
  assign word_we = pop && ((q_entry.op == OP_WORD) || (q_entry.op == OP_SEARCH));

  assign grid_waddr = GA'(GA'(q_entry.row) * GA'(GRID_MAX) + GA'(q_entry.col));
  assign grid_raddr = GA'(GA'(cur_r[GW-1:0]) * GA'(GRID_MAX) + GA'(cur_c[GW-1:0]));

  assign outside = cur_r[PW-1] || cur_c[PW-1] ||
                   (cur_r >= $signed({1'b0, n})) || (cur_c >= $signed({1'b0, n}));
  assign c_last  = (NW'(c) == n - NW'(1));
  assign r_last  = (dir == SCAN_UR) ? (r == '0) : (NW'(r) == n - NW'(1));

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= q_entry.symbol;
    end
    grid_rd <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[WA'(q_entry.pos)] <= q_entry.symbol;
    end
    word_rd <= word_mem[k];
  end

  always_comb begin
    state_next   = state;
    dir_next     = dir;
    r_next       = r;
    c_next       = c;
    k_next       = k;
    len_m1_next  = len_m1;
    n_next       = n;
    cur_r_next   = cur_r;
    cur_c_next   = cur_c;
    hit_next     = hit;
    hit_r_next   = hit_r;
    hit_c_next   = hit_c;
    hit_dir_next = hit_dir;
    adv          = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_entry.op)
            OP_SEARCH: begin
              len_m1_next  = WA'(q_entry.pos);
              n_next       = NW'(n_calc);
              dir_next     = SCAN_H;
              r_next       = '0;
              c_next       = '0;
              k_next       = '0;
              cur_r_next   = '0;
              cur_c_next   = '0;
              hit_next     = 1'b0;
              hit_r_next   = '0;
              hit_c_next   = '0;
              hit_dir_next = DIR_HORZ;
              state_next   = (n_calc == '0) ? S_DONE : S_ISSUE;
            end
            OP_MISS: begin
              hit_next     = 1'b0;
              hit_r_next   = '0;
              hit_c_next   = '0;
              hit_dir_next = DIR_HORZ;
              state_next   = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        // a run that leaves the grid fails without a memory access
        if (outside) begin
          adv = 1'b1;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (grid_rd != word_rd) begin
          adv = 1'b1;
        end else if (k == len_m1) begin
          hit_next   = 1'b1;
          hit_r_next = r;
          hit_c_next = c;
          case (dir)
            SCAN_H:  hit_dir_next = DIR_HORZ;
            SCAN_V:  hit_dir_next = DIR_VERT;
            default: hit_dir_next = DIR_DIAG;
          endcase
          // straight passes stop at the first hit, diagonals keep the last one
          if ((dir == SCAN_H) || (dir == SCAN_V)) begin
            state_next = S_DONE;
          end else begin
            adv = 1'b1;
          end
        end else begin
          k_next     = k + WA'(1);
          state_next = S_ISSUE;
          case (dir)
            SCAN_H: begin
              cur_c_next = cur_c + PW'(1);
            end
            SCAN_V: begin
              cur_r_next = cur_r + PW'(1);
            end
            SCAN_DR: begin
              cur_r_next = cur_r + PW'(1);
              cur_c_next = cur_c + PW'(1);
            end
            default: begin
              cur_r_next = cur_r - PW'(1);
              cur_c_next = cur_c + PW'(1);
            end
          endcase
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // move to the next start cell, and to the next pass at the end of one
    if (adv) begin
      k_next     = '0;
      state_next = S_ISSUE;
      if (c_last) begin
        c_next = '0;
        if (r_last) begin
          case (dir)
            SCAN_H: begin
              dir_next = SCAN_V;
              r_next   = '0;
            end
            SCAN_V: begin
              dir_next = SCAN_DR;
              r_next   = '0;
            end
            SCAN_DR: begin
              if (hit_next) begin
                state_next = S_DONE;
              end else begin
                dir_next = SCAN_UR;
                r_next   = GW'(n - NW'(1));
              end
            end
            default: state_next = S_DONE;
          endcase
        end else begin
          r_next = (dir == SCAN_UR) ? r - GW'(1) : r + GW'(1);
        end
      end else begin
        c_next = c + GW'(1);
      end
      cur_r_next = PW'(r_next);
      cur_c_next = PW'(c_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    dir     <= dir_next;
    r       <= r_next;
    c       <= c_next;
    k       <= k_next;
    len_m1  <= len_m1_next;
    n       <= n_next;
    cur_r   <= cur_r_next;
    cur_c   <= cur_c_next;
    hit     <= hit_next;
    hit_r   <= hit_r_next;
    hit_c   <= hit_c_next;
    hit_dir <= hit_dir_next;
  end

  // result register
  assign load      = (state == S_DONE) && (!rsp_valid || rsp.ready);
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.data.found     <= hit;
      rsp.data.hit_row   <= 5'(hit_r);
      rsp.data.hit_col   <= 5'(hit_c);
      rsp.data.direction <= hit_dir;
    end
  end

endmodule

@@ rtl/core/grid_word_search.sv @@
// Grid word search: one grid or word character per cycle while the engine is idle;
// a search holds the engine for up to 4*n*n start cells, four passes of n*n each.
// Each compare is a registered read of the grid and word memories.
// Steps run through issue and compare states; the done state loads the result.
// Synchronous active-high reset clears control and sets grid_size to 32;
// grid and word memories hold garbage until written.
`timescale 1ns / 1ps

module grid_word_search #(
  parameter int GRID_MAX = 32,
  parameter int WORD_MAX = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gws_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gws_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gws_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  gws_req_if.sink                        req,
  gws_rsp_if.source                      rsp
);
  import gws_pkg::*;

  logic [GSZ_W-1:0] grid_size;
  logic             q_valid;
  logic             q_ready;
  gws_q_t           q_entry;
  logic             reg_hit;

  // one register, word aligned: ignore the byte offset bits
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DATA_W'(grid_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      grid_size <= pwdata[GSZ_W-1:0];
    end
  end

  gws_front #(
    .GRID_MAX (GRID_MAX),
    .WORD_MAX (WORD_MAX)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_ready (q_ready)
  );

  gws_back #(
    .GRID_MAX (GRID_MAX),
    .WORD_MAX (WORD_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .grid_size (grid_size),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_ready   (q_ready),
    .rsp       (rsp)
  );

endmodule

@@ rtl/core/gws_checker.sv @@
// Port-level checks on the result channel of grid_word_search, bound to the top.
// Depends on gws_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gws_checker (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input gws_pkg::gws_rsp_t rsp_data
);
  import gws_pkg::*;

  // a stalled result keeps its payload
  `ASSERT_CLK_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

  // a miss reports zero position and direction
  `ASSERT_CLK_RST(a_miss_zero, clk, rst, rsp_valid && !rsp_data.found |-> (rsp_data.hit_row == 5'd0) && (rsp_data.hit_col == 5'd0) && (rsp_data.direction == DIR_HORZ), "miss with nonzero fields")

  `ASSERT_CLK_RST(a_dir_code, clk, rst, rsp_valid |-> (rsp_data.direction == DIR_HORZ) || (rsp_data.direction == DIR_VERT) || (rsp_data.direction == DIR_DIAG), "bad direction code")

  `ASSERT_CLK(a_rst_clear, clk, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind grid_word_search gws_checker u_gws_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

@@ verif/tb_grid_word_search.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for grid_word_search: loads grids over the request channel,
// sends query words and checks every result against a predictor of the search.
// Depends on gws_pkg, the stream interfaces in gws_if.sv and the grid_word_search RTL.

module tb_grid_word_search;
  import gws_pkg::*;

  localparam int GRID_MAX      = 32;
  localparam int WORD_MAX      = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GRID_SIZE = '0;
  localparam int STALL_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 25;
  localparam int NUM_PHASES    = 11;
  localparam byte unsigned LETTER_A = 8'h41;

  typedef byte unsigned word_q_t[$];

  // Mirror of grid and word buffer, plus the results still owed by the block.
  class hit_scoreboard;
    byte unsigned cells [GRID_MAX][GRID_MAX];
    byte unsigned letters [WORD_MAX];
    int           side;
    gws_rsp_t     awaited_hits[$];
    int           mismatches;

    function new();
      side       = GRID_MAX;
      mismatches = 0;
    endfunction

    function void set_grid_size(logic [GSZ_W-1:0] v);
      side = (v > GRID_MAX) ? GRID_MAX : int'(v);
    endfunction

    function bit run_hits(int r, int c, int dr, int dc, int len);
      int rr, cc;
      for (int k = 0; k < len; k++) begin
        rr = r + dr * k;
        cc = c + dc * k;
        if (rr < 0 || rr >= side || cc < 0 || cc >= side) return 1'b0;
        if (cells[rr][cc] != letters[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function gws_rsp_t locate_word(int len);
      gws_rsp_t hit;
      hit = '0;
      for (int r = 0; r < side; r++)
        for (int c = 0; c < side; c++)
          if (!hit.found && run_hits(r, c, 0, 1, len)) begin
            hit = '{found: 1'b1, hit_row: 5'(r), hit_col: 5'(c), direction: DIR_HORZ};
          end
      for (int r = 0; r < side; r++)
        for (int c = 0; c < side; c++)
          if (!hit.found && run_hits(r, c, 1, 0, len)) begin
            hit = '{found: 1'b1, hit_row: 5'(r), hit_col: 5'(c), direction: DIR_VERT};
          end
      // diagonals keep the last match in scan order
      if (!hit.found) begin
        for (int r = 0; r < side; r++)
          for (int c = 0; c < side; c++)
            if (run_hits(r, c, 1, 1, len)) begin
              hit = '{found: 1'b1, hit_row: 5'(r), hit_col: 5'(c), direction: DIR_DIAG};
            end
      end
      if (!hit.found) begin
        for (int r = side - 1; r >= 0; r--)
          for (int c = 0; c < side; c++)
            if (run_hits(r, c, -1, 1, len)) begin
              hit = '{found: 1'b1, hit_row: 5'(r), hit_col: 5'(c), direction: DIR_DIAG};
            end
      end
      return hit;
    endfunction

    function void note_request(gws_req_t r);
      if (r.func == FUNC_CELL) begin
        cells[r.cell_row][r.cell_col] = r.symbol;
        return;
      end
      letters[r.word_pos] = r.symbol;
      if (r.word_end) awaited_hits.push_back(locate_word(int'(r.word_pos) + 1));
    endfunction

    function void check_field(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(gws_rsp_t got);
      gws_rsp_t want;
      if (awaited_hits.size() == 0) begin
        $error("result with no search outstanding: found=%0d row=%0d col=%0d dir=%0d",
               got.found, got.hit_row, got.hit_col, got.direction);
        mismatches++;
        return;
      end
      want = awaited_hits.pop_front();
      check_field("found", 5'(want.found), 5'(got.found));
      check_field("hit_row", want.hit_row, got.hit_row);
      check_field("hit_col", want.hit_col, got.hit_col);
      check_field("direction", 5'(want.direction), 5'(got.direction));
    endfunction

    function int pending();
      return awaited_hits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  gws_req_if req_ch ();
  gws_rsp_if rsp_ch ();

  hit_scoreboard sb = new();
  bit cell_set [GRID_MAX][GRID_MAX];
  bit pos_set [WORD_MAX];
  int items_sent = 0;
  bit steady     = 1'b0;
  bit hold_rsp   = 1'b0;

  grid_word_search #(
    .GRID_MAX(GRID_MAX),
    .WORD_MAX(WORD_MAX)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  always #5 clk = ~clk;

  // Grid text mostly from a four-letter alphabet so words actually hit.
  function automatic byte unsigned letter();
    if ($urandom_range(0, 99) < 85) return 8'(LETTER_A + $urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic word_q_t make_word();
    word_q_t w;
    int len, d, dr, dc, r0, c0, pick;
    pick = $urandom_range(0, 99);
    if (sb.side > 8) begin
      // only row 0 of a big grid is loaded: a slice of it hits there first
      len = $urandom_range(1, 4);
      c0  = $urandom_range(0, sb.side - len);
      for (int k = 0; k < len; k++) w.push_back(sb.cells[0][c0 + k]);
      return w;
    end
    if (pick < 5) len = WORD_MAX;
    else if (pick < 30) len = $urandom_range(1, sb.side + 1);
    else len = $urandom_range(1, 3);
    if (len <= sb.side && $urandom_range(0, 3) != 0) begin
      // lift the word off the grid along a random direction
      d  = $urandom_range(0, 3);
      dr = (d == 1 || d == 2) ? 1 : ((d == 3) ? -1 : 0);
      dc = (d == 1) ? 0 : 1;
      if (dr < 0) r0 = $urandom_range(len - 1, sb.side - 1);
      else if (dr > 0) r0 = $urandom_range(0, sb.side - len);
      else r0 = $urandom_range(0, sb.side - 1);
      c0 = (dc > 0) ? $urandom_range(0, sb.side - len) : $urandom_range(0, sb.side - 1);
      for (int k = 0; k < len; k++) w.push_back(sb.cells[r0 + dr * k][c0 + dc * k]);
      if ($urandom_range(0, 3) == 0) w[$urandom_range(0, len - 1)] = letter();
    end else begin
      for (int k = 0; k < len; k++) w.push_back(letter());
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance, valid still up.
  task automatic send_req(input gws_req_t r);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (r.func == FUNC_CELL) cell_set[r.cell_row][r.cell_col] = 1'b1;
    else pos_set[r.word_pos] = 1'b1;
    items_sent++;
  endtask

  task automatic cell_req(input int row, input int col, input byte unsigned sym);
    gws_req_t r;
    r.func     = FUNC_CELL;
    r.cell_row = 5'(row);
    r.cell_col = 5'(col);
    r.symbol   = sym;
    r.word_pos = 5'($urandom_range(0, 31));
    r.word_end = 1'($urandom_range(0, 1));
    send_req(r);
  endtask

  task automatic word_char(input int pos, input byte unsigned sym, input bit last);
    gws_req_t r;
    r.func     = FUNC_WORD;
    r.cell_row = 5'($urandom_range(0, 31));
    r.cell_col = 5'($urandom_range(0, 31));
    r.symbol   = sym;
    r.word_pos = 5'(pos);
    r.word_end = last;
    send_req(r);
  endtask

  task automatic send_word(input word_q_t w);
    foreach (w[k]) word_char(k, w[k], k == w.size() - 1);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Resize only with the engine idle, then load what the searches will read:
  // all of a small grid, row 0 of a big one.
  task automatic cfg_write(input logic [GSZ_W-1:0] size);
    logic [CFG_DATA_W-1:0] wdata;
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    wdata            = $urandom();
    wdata[GSZ_W-1:0] = size;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_GRID_SIZE;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_grid_size(size);
    for (int r = 0; r < ((sb.side > 8) ? 1 : sb.side); r++)
      for (int c = 0; c < sb.side; c++)
        if (!cell_set[r][c]) cell_req(r, c, letter());
  endtask

  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : monitor
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      quiet++;
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.data);
        quiet = 0;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_result(rsp_ch.data);
        quiet = 0;
      end
    end
    $display("tb_grid_word_search: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [GSZ_W-1:0] sizes [NUM_PHASES];
    int stop, sel, prefix;
    sizes = '{6'd1, 6'd0, 6'd5, 6'd2, 6'd8, 6'd63, 6'd3, 6'd40, 6'd6, 6'd32, 6'd7};
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 grid:  A B FF / D A B / 00 D A
    cell_req(0, 0, "A");
    cell_req(0, 1, "B");
    cell_req(0, 2, 8'hFF);
    cell_req(1, 0, "D");
    cell_req(1, 1, "A");
    cell_req(1, 2, "B");
    cell_req(2, 0, 8'h00);
    cell_req(2, 1, "D");
    cell_req(2, 2, "A");
    cfg_write(6'd3);
    send_word('{"A", "B"});             // horizontal
    send_word('{"A", "D"});             // vertical
    send_word('{"A", "A"});             // down-right, two hits, later one wins
    send_word('{"D", "B"});             // up-right, two hits, upper start wins
    send_word('{8'h00, "A"});           // up-right from a zero byte
    send_word('{"A", "A", "A", "A"});   // longer than the grid

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cfg_write(sizes[ph]);
      steady = (ph == 2);
      if (ph == 0) begin
        // results pile up behind a stalled receiver until the input backs up
        hold_rsp = 1'b1;
        repeat (40) word_char(0, letter(), 1'b1);
      end
      stop = items_sent + ((sb.side > 8) ? 16 : 40);
      while (items_sent < stop) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          send_word(make_word());
        end else if (sel < 78 && sb.side > 0) begin
          cell_req($urandom_range(0, sb.side - 1), $urandom_range(0, sb.side - 1), letter());
        end else if (sel < 88) begin
          cell_req($urandom_range(0, 31), $urandom_range(0, 31), 8'($urandom_range(0, 255)));
        end else if (sel < 94) begin
          word_char($urandom_range(0, WORD_MAX - 1), 8'($urandom_range(0, 255)), 1'b0);
        end else if (sb.side <= 8) begin
          // lone final mark: length taken from whatever the buffer already holds
          prefix = 0;
          while (prefix < WORD_MAX && pos_set[prefix]) prefix++;
          word_char($urandom_range(0, (prefix < WORD_MAX) ? prefix : WORD_MAX - 1),
                    letter(), 1'b1);
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_grid_word_search: PASS");
    end else begin
      $display("tb_grid_word_search: FAIL");
    end
    $finish;
  end

endmodule
